FILE: rtl/core/i2cmts_pkg.sv
`default_nettype none

package i2cmts_pkg;

    // Input item kinds.
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_EVENT = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    // Requested operations.
    localparam logic [1:0] OP_WRITE     = 2'd0;
    localparam logic [1:0] OP_CMD_WRITE = 2'd1;
    localparam logic [1:0] OP_READ      = 2'd2;
    localparam logic [1:0] OP_CMD_READ  = 2'd3;

    // Bus event codes.
    localparam logic [2:0] EV_START_SENT = 3'd0;
    localparam logic [2:0] EV_ADDR_ACK   = 3'd1;
    localparam logic [2:0] EV_XFER_DONE  = 3'd2;
    localparam logic [2:0] EV_RX_FULL    = 3'd3;
    localparam logic [2:0] EV_TX_EMPTY   = 3'd4;

    // Bus actions.
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_START   = 3'd1;
    localparam logic [2:0] ACT_ADDR_W  = 3'd2;
    localparam logic [2:0] ACT_ADDR_R  = 3'd3;
    localparam logic [2:0] ACT_SEND    = 3'd4;
    localparam logic [2:0] ACT_RESTART = 3'd5;
    localparam logic [2:0] ACT_STOP    = 3'd6;

    typedef enum logic [9:0] {
        PH_IDLE      = 10'b0000000001,
        PH_TX_START  = 10'b0000000010,
        PH_TX_ADDR   = 10'b0000000100,
        PH_TX_DATA   = 10'b0000001000,
        PH_RX_START  = 10'b0000010000,
        PH_RX_ADDR   = 10'b0000100000,
        PH_RX_CMD    = 10'b0001000000,
        PH_RX_START2 = 10'b0010000000,
        PH_RX_ADDR2  = 10'b0100000000,
        PH_RX_DATA   = 10'b1000000000
    } t_phase;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] bus_byte;
        logic       rx_write;
        logic [7:0] rx_index;
        logic [7:0] rx_value;
        logic       done_res;
        logic       failed;
        logic       busy_res;
        logic       refused;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/core/i2c_master_transaction_sequencer.sv
// I2C master transaction sequencer, seven-bit addressing.
// Input channel (i_valid / o_stall) carries one item per transfer: a transmit
// byte to load into the buffer, a start request, a bus event or an error event.
// Output channel (o_valid / i_stall) returns exactly one result per input item:
// the bus action to take, the byte for the bus, an optional received byte with
// its index, and the done, failed, busy and refused flags.
// Each item is processed in the cycle it is accepted; its result goes to the
// output register, or to the skid register while that is held. One item is
// accepted every cycle while o_stall is low. The transmit buffer read is
// registered; it reads at the byte counter the accepted item leaves behind,
// with a bypass for a load to the same position, so it never limits the rate.
// A two-entry output stage (output register plus skid register) keeps the
// input side running while one result waits; o_stall rises only when both
// entries hold results that the receiver has not taken.
// Reset returns the sequencer to idle and empties the output stage. The
// transmit buffer is not cleared; send only positions that have been loaded.
`default_nettype none

module i2c_master_transaction_sequencer #(
    parameter int TX_BUFFER_DEPTH = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_kind,
    input  wire logic [1:0] i_op,
    input  wire logic [6:0] i_device_address,
    input  wire logic [7:0] i_command_byte,
    input  wire logic [7:0] i_byte_count,
    input  wire logic [2:0] i_event_code,
    input  wire logic [7:0] i_data_byte,
    input  wire logic [7:0] i_load_index,
    input  wire logic [7:0] i_error_flags,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [2:0]      o_action,
    output logic [7:0]      o_bus_byte,
    output logic            o_rx_write,
    output logic [7:0]      o_rx_index,
    output logic [7:0]      o_rx_value,
    output logic            o_done_res,
    output logic            o_failed,
    output logic            o_busy_res,
    output logic            o_refused
);

    localparam int AW = (TX_BUFFER_DEPTH > 1) ? $clog2(TX_BUFFER_DEPTH) : 1;

    i2cmts_pkg::t_phase  r_phase, n_phase;
    logic [1:0]          r_mode, n_mode;
    logic [6:0]          r_target_address, n_target_address;
    logic [7:0]          r_command_value, n_command_value;
    logic [7:0]          r_total_bytes, n_total_bytes;
    logic [7:0]          r_byte_counter, n_byte_counter;

    logic [7:0]          tx_mem [TX_BUFFER_DEPTH];
    logic [7:0]          r_rd_data;
    logic                r_rd_ok;

    i2cmts_pkg::t_result r_out, r_skid, res;
    logic                r_out_valid, r_skid_valid;

    logic                accept_in, out_take;
    logic                wr_en, rd_in_range;
    logic [7:0]          rd_addr, bc_inc, tx_byte;
    logic [7:0]          aw;

    assign o_stall   = r_skid_valid;
    assign accept_in = i_valid && !r_skid_valid;
    assign out_take  = r_out_valid && !i_stall;

    assign aw      = {r_target_address, 1'b0};
    assign bc_inc  = r_byte_counter + 8'd1;
    assign tx_byte = r_rd_ok ? r_rd_data : 8'd0;

    always_comb begin
        n_phase          = r_phase;
        n_mode           = r_mode;
        n_target_address = r_target_address;
        n_command_value  = r_command_value;
        n_total_bytes    = r_total_bytes;
        n_byte_counter   = r_byte_counter;
        res              = '0;

        case (i_kind)
            i2cmts_pkg::KIND_LOAD: begin
            end
            i2cmts_pkg::KIND_START: begin
                if (r_phase != i2cmts_pkg::PH_IDLE) begin
                    res.refused = 1'b1;
                end else begin
                    n_mode           = i_op;
                    n_target_address = i_device_address;
                    n_command_value  = i_command_byte;
                    n_total_bytes    = i_byte_count;
                    n_byte_counter   = 8'd0;
                    n_phase          = (i_op inside {i2cmts_pkg::OP_WRITE,
                                                     i2cmts_pkg::OP_CMD_WRITE})
                                       ? i2cmts_pkg::PH_TX_START
                                       : i2cmts_pkg::PH_RX_START;
                    res.action       = i2cmts_pkg::ACT_START;
                end
            end
            i2cmts_pkg::KIND_ERROR: begin
                // The bus peripheral is reset, so no action goes out.
                if (r_phase != i2cmts_pkg::PH_IDLE) begin
                    n_phase      = i2cmts_pkg::PH_IDLE;
                    res.done_res = 1'b1;
                    res.failed   = 1'b1;
                end
            end
            default: begin
                case (r_phase)
                    i2cmts_pkg::PH_TX_START: begin
                        if (i_event_code == i2cmts_pkg::EV_START_SENT) begin
                            res.action   = i2cmts_pkg::ACT_ADDR_W;
                            res.bus_byte = aw;
                            n_phase      = i2cmts_pkg::PH_TX_ADDR;
                        end
                    end
                    i2cmts_pkg::PH_TX_ADDR: begin
                        if (i_event_code == i2cmts_pkg::EV_ADDR_ACK) begin
                            if (r_mode == i2cmts_pkg::OP_CMD_WRITE) begin
                                res.action   = i2cmts_pkg::ACT_SEND;
                                res.bus_byte = r_command_value;
                                n_phase      = i2cmts_pkg::PH_TX_DATA;
                            end else if (r_total_bytes == 8'd0) begin
                                res.action   = i2cmts_pkg::ACT_STOP;
                                res.done_res = 1'b1;
                                n_phase      = i2cmts_pkg::PH_IDLE;
                            end else begin
                                res.action     = i2cmts_pkg::ACT_SEND;
                                res.bus_byte   = tx_byte;
                                n_byte_counter = bc_inc;
                                n_phase        = i2cmts_pkg::PH_TX_DATA;
                            end
                        end
                    end
                    i2cmts_pkg::PH_TX_DATA: begin
                        if (i_event_code == i2cmts_pkg::EV_TX_EMPTY) begin
                            if (r_byte_counter < r_total_bytes) begin
                                res.action     = i2cmts_pkg::ACT_SEND;
                                res.bus_byte   = tx_byte;
                                n_byte_counter = bc_inc;
                            end
                        end else if (i_event_code == i2cmts_pkg::EV_XFER_DONE) begin
                            res.action   = i2cmts_pkg::ACT_STOP;
                            res.done_res = 1'b1;
                            n_phase      = i2cmts_pkg::PH_IDLE;
                        end else begin
                            // Any other event while sending data aborts the transaction.
                            res.done_res = 1'b1;
                            res.failed   = 1'b1;
                            n_phase      = i2cmts_pkg::PH_IDLE;
                        end
                    end
                    i2cmts_pkg::PH_RX_START: begin
                        if (i_event_code == i2cmts_pkg::EV_START_SENT) begin
                            if (r_mode == i2cmts_pkg::OP_CMD_READ) begin
                                res.action   = i2cmts_pkg::ACT_ADDR_W;
                                res.bus_byte = aw;
                            end else begin
                                res.action   = i2cmts_pkg::ACT_ADDR_R;
                                res.bus_byte = aw | 8'd1;
                            end
                            n_phase = i2cmts_pkg::PH_RX_ADDR;
                        end
                    end
                    i2cmts_pkg::PH_RX_ADDR, i2cmts_pkg::PH_RX_ADDR2: begin
                        if (i_event_code == i2cmts_pkg::EV_ADDR_ACK) begin
                            if (r_phase == i2cmts_pkg::PH_RX_ADDR &&
                                r_mode == i2cmts_pkg::OP_CMD_READ) begin
                                res.action   = i2cmts_pkg::ACT_SEND;
                                res.bus_byte = r_command_value;
                                n_phase      = i2cmts_pkg::PH_RX_CMD;
                            end else if (r_total_bytes == 8'd0) begin
                                res.action   = i2cmts_pkg::ACT_STOP;
                                res.done_res = 1'b1;
                                n_phase      = i2cmts_pkg::PH_IDLE;
                            end else begin
                                n_phase = i2cmts_pkg::PH_RX_DATA;
                            end
                        end
                    end
                    i2cmts_pkg::PH_RX_CMD: begin
                        if (i_event_code == i2cmts_pkg::EV_XFER_DONE) begin
                            res.action = i2cmts_pkg::ACT_RESTART;
                            n_phase    = i2cmts_pkg::PH_RX_START2;
                        end
                    end
                    i2cmts_pkg::PH_RX_START2: begin
                        if (i_event_code == i2cmts_pkg::EV_START_SENT) begin
                            res.action   = i2cmts_pkg::ACT_ADDR_R;
                            res.bus_byte = aw | 8'd1;
                            n_phase      = i2cmts_pkg::PH_RX_ADDR2;
                        end
                    end
                    i2cmts_pkg::PH_RX_DATA: begin
                        if (i_event_code == i2cmts_pkg::EV_RX_FULL) begin
                            res.rx_write   = 1'b1;
                            res.rx_index   = r_byte_counter;
                            res.rx_value   = i_data_byte;
                            n_byte_counter = bc_inc;
                            if (bc_inc >= r_total_bytes) begin
                                res.action   = i2cmts_pkg::ACT_STOP;
                                res.done_res = 1'b1;
                                n_phase      = i2cmts_pkg::PH_IDLE;
                            end
                        end
                    end
                    default: begin
                        n_phase = i2cmts_pkg::PH_IDLE;
                    end
                endcase
            end
        endcase

        res.busy_res = (n_phase != i2cmts_pkg::PH_IDLE);
    end

    // The buffer is read at the position the counter holds after this cycle,
    // so the data is ready when the next item needs it.
    assign rd_addr     = accept_in ? n_byte_counter : r_byte_counter;
    assign rd_in_range = ({1'b0, rd_addr} < 9'(TX_BUFFER_DEPTH));
    assign wr_en       = accept_in && (i_kind == i2cmts_pkg::KIND_LOAD) &&
                         ({1'b0, i_load_index} < 9'(TX_BUFFER_DEPTH));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            tx_mem[i_load_index[AW-1:0]] <= i_data_byte;
        end
        if (wr_en && i_load_index == rd_addr) begin
            r_rd_data <= i_data_byte;
        end else begin
            r_rd_data <= tx_mem[rd_addr[AW-1:0]];
        end
        r_rd_ok <= rd_in_range;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= i2cmts_pkg::PH_IDLE;
            r_mode           <= 2'd0;
            r_target_address <= 7'd0;
            r_command_value  <= 8'd0;
            r_total_bytes    <= 8'd0;
            r_byte_counter   <= 8'd0;
        end else if (accept_in) begin
            r_phase          <= n_phase;
            r_mode           <= n_mode;
            r_target_address <= n_target_address;
            r_command_value  <= n_command_value;
            r_total_bytes    <= n_total_bytes;
            r_byte_counter   <= n_byte_counter;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else if (accept_in) begin
                r_out <= res;
            end else begin
                r_out_valid <= 1'b0;
            end
        end else if (accept_in) begin
            if (r_out_valid) begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end else begin
                r_out       <= res;
                r_out_valid <= 1'b1;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_action   = r_out.action;
    assign o_bus_byte = r_out.bus_byte;
    assign o_rx_write = r_out.rx_write;
    assign o_rx_index = r_out.rx_index;
    assign o_rx_value = r_out.rx_value;
    assign o_done_res = r_out.done_res;
    assign o_failed   = r_out.failed;
    assign o_busy_res = r_out.busy_res;
    assign o_refused  = r_out.refused;

endmodule

`default_nettype wire
